// File: hdl/sbde_pkg.sv
// Shared types, constants and tables of the split-band de-esser.
`default_nettype none
package sbde_pkg;

  localparam int MAX_CHANNELS_DEF   = 8;
  localparam int DETECTOR_COEFF_DEF = 65081;

  localparam int LANES    = 8;
  localparam int SAMPLE_W = 24;
  localparam int MUL_W    = 34;

  localparam logic [17:0] DB_PER_LOG2    = 18'd197283;
  localparam logic [21:0] LOG2_10_Q24    = 22'd2786635;
  localparam logic [4:0]  ENERGY_FLOOR   = 5'd18;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_ENABLED   = 3'd0;
  localparam logic [2:0] REG_BAND_GAIN = 3'd1;
  localparam logic [2:0] REG_BAND_FB   = 3'd2;
  localparam logic [2:0] REG_ATTACK    = 3'd3;
  localparam logic [2:0] REG_RELEASE   = 3'd4;
  localparam logic [2:0] REG_THRESHOLD = 3'd5;
  localparam logic [2:0] REG_AMOUNT    = 3'd6;
  localparam logic [2:0] REG_MAX_RED   = 3'd7;

  typedef enum logic [4:0] {
    S_IDLE, S_B0X, S_Y, S_A1Y, S_A2Y, S_S2, S_YY, S_XX,
    S_EMUL, S_EACC, S_LLOAD, S_LNORM, S_LSQ, S_LSTEP,
    S_DBMUL, S_DBEXC, S_AMT, S_TGT, S_SRMUL, S_SRACC,
    S_DISMUL, S_DISACC, S_CFMUL, S_CFEXP, S_CFMUL2, S_CFSTEP,
    S_CFSHIFT, S_SUBMUL, S_SUBACC, S_DONE
  } state_t;

  function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
    logic signed [23:0] r;
    if (v > 40'sd8388607) r = 24'sh7FFFFF;
    else if (v < -40'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Successive square roots of one half in Q1.30: entry k holds 2^-(2^-(k+1)).
  function automatic logic [16*31-1:0] sqrt_table();
    logic [63:0] t;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    logic [16*31-1:0] tab;
    t = 64'd1 << 29;
    tab = '0;
    for (int k = 0; k < 16; k++) begin
      v = t << 30;
      res = 64'd0;
      bt = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
        if (bt > v) bt = bt >> 2;
      end
      for (int i = 0; i < 32; i++) begin
        if (bt != 64'd0) begin
          if (v >= res + bt) begin
            v = v - (res + bt);
            res = (res >> 1) + bt;
          end else begin
            res = res >> 1;
          end
          bt = bt >> 2;
        end
      end
      t = res;
      tab[k*31 +: 31] = t[30:0];
    end
    return tab;
  endfunction

  localparam logic [16*31-1:0] SQRT_TAB = sqrt_table();

endpackage
`default_nettype wire

// File: hdl/split_band_de_esser_core.sv
// Split-band de-esser: top level with register file, sequencer and datapath.
//
// Frames arrive on the in_ stream: eight 24-bit samples in in_tdata and the
// channel count in in_tuser. Each accepted transaction produces exactly one
// out_ transaction carrying the eight processed samples and the reduction now
// applied in dB. Settings are written through the cfg_ APB-style port; the
// user must write them only while the block is idle, as the block itself does
// not enforce it. pready is always high and reads return the register. All
// arithmetic goes through one 34x34 multiplier under a sequencer, one frame
// at a time: the bandpass for each channel, the detectors, two logarithms
// (one-bit-a-cycle normalisation plus 16 squarings each), and, when a
// reduction applies, the dB-to-gain conversion and the per-channel subtraction.
// A disabled frame only decays the reduction. in_tready is high only while the
// sequencer is idle. The result sits in an output register, so a new frame
// may be accepted while it waits; if the receiver still stalls when the next
// frame finishes, the sequencer holds. Synchronous reset clears filter states,
// detectors and reduction and returns the settings to their reset values.
`default_nettype none
module split_band_de_esser_core #(
  parameter int MAX_CHANNELS   = sbde_pkg::MAX_CHANNELS_DEF,
  parameter int DETECTOR_COEFF = sbde_pkg::DETECTOR_COEFF_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [191:0] in_tdata,   // sample_0 .. sample_7, 24 bits each
  input  wire logic [3:0]   in_tuser,   // active_channels
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [207:0]      out_tdata,  // out_0 .. out_7 (24 each), reduction_db (13)
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [15:0] DCOEF  = 16'(DETECTOR_COEFF);
  localparam logic [16:0] DCOMPL = 17'(65536 - DETECTOR_COEFF);
  localparam logic [3:0]  MAXCH  = 4'(MAX_CHANNELS);

  // ---------------- configuration registers ----------------
  logic        enabled_r;
  logic [30:0] b0_r;
  logic [31:0] a1_r;
  logic [15:0] att_r, rel_r, thr_r;
  logic [13:0] amt_r;
  logic [12:0] maxr_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      b0_r      <= '0;
      a1_r      <= '0;
      att_r     <= '0;
      rel_r     <= '0;
      thr_r     <= 16'hF600;
      amt_r     <= 14'd4096;
      maxr_r    <= 13'd1536;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr[4:2])
        sbde_pkg::REG_ENABLED:   enabled_r <= cfg_pwdata[0];
        sbde_pkg::REG_BAND_GAIN: b0_r      <= cfg_pwdata[30:0];
        sbde_pkg::REG_BAND_FB:   a1_r      <= cfg_pwdata;
        sbde_pkg::REG_ATTACK:    att_r     <= cfg_pwdata[15:0];
        sbde_pkg::REG_RELEASE:   rel_r     <= cfg_pwdata[15:0];
        sbde_pkg::REG_THRESHOLD: thr_r     <= cfg_pwdata[15:0];
        sbde_pkg::REG_AMOUNT:    amt_r     <= cfg_pwdata[13:0];
        sbde_pkg::REG_MAX_RED:   maxr_r    <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      sbde_pkg::REG_ENABLED:   cfg_prdata = {31'd0, enabled_r};
      sbde_pkg::REG_BAND_GAIN: cfg_prdata = {1'b0, b0_r};
      sbde_pkg::REG_BAND_FB:   cfg_prdata = a1_r;
      sbde_pkg::REG_ATTACK:    cfg_prdata = {16'd0, att_r};
      sbde_pkg::REG_RELEASE:   cfg_prdata = {16'd0, rel_r};
      sbde_pkg::REG_THRESHOLD: cfg_prdata = {16'd0, thr_r};
      sbde_pkg::REG_AMOUNT:    cfg_prdata = {18'd0, amt_r};
      sbde_pkg::REG_MAX_RED:   cfg_prdata = {19'd0, maxr_r};
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- datapath state ----------------
  sbde_pkg::state_t state_r, state_nxt;
  logic [3:0]  ch_r, ch_nxt, kept_r, kept_nxt, k_r, k_nxt;
  logic signed [23:0] x_r [sbde_pkg::LANES];
  logic signed [23:0] x_nxt [sbde_pkg::LANES];
  logic signed [23:0] y_r [sbde_pkg::LANES];
  logic signed [23:0] y_nxt [sbde_pkg::LANES];
  logic signed [31:0] s1_mem [MAX_CHANNELS];
  logic signed [31:0] s2_mem [MAX_CHANNELS];
  logic        s1_we, s2_we;
  logic signed [31:0] s1_wd, s2_wd;
  logic signed [55:0] p1_r, p1_nxt;
  logic [49:0] bsq_r, bsq_nxt, fsq_r, fsq_nxt;
  logic [65:0] acc_r, acc_nxt;
  logic [47:0] be_r, be_nxt, fe_r, fe_nxt;
  logic [48:0] lgv_r, lgv_nxt;
  logic [5:0]  lgn_r, lgn_nxt;
  logic [31:0] lgm_r, lgm_nxt;
  logic [15:0] lgf_r, lgf_nxt;
  logic        lsel_r, lsel_nxt;
  logic [21:0] lb_r, lb_nxt, lf_r, lf_nxt;
  logic signed [21:0] ex_r, ex_nxt;
  logic [12:0] tgt_r, tgt_nxt, sr_r, sr_nxt;
  logic [3:0]  ip_r, ip_nxt;
  logic [15:0] fp_r, fp_nxt;
  logic [30:0] lin_r, lin_nxt, g_r, g_nxt;
  logic        ov_r, ov_nxt;
  logic signed [23:0] ox_r [sbde_pkg::LANES];
  logic [12:0] ordb_r;
  logic        out_load;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;

  sbde_mul #(.W(sbde_pkg::MUL_W)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  logic [2:0]      lane;
  logic [IW-1:0]   mi;
  logic signed [23:0] xl, yl;
  logic signed [31:0] s1_rd, s2_rd;
  logic signed [67:0] rnd_p, rnd_n, rnd_s2;
  logic signed [37:0] r30_p, r30_n, r30_s2;
  logic [65:0] esum;
  logic [65:0] ssum;
  logic [32:0] sq;
  logic signed [22:0] dlog;
  logic signed [67:0] rnd24;
  logic [15:0] csel;
  logic [3:0]  kin;
  logic [35:0] ecf;
  logic [67:0] rlin;

  assign lane  = ch_r[2:0];
  assign mi    = ch_r[IW-1:0];
  assign xl    = x_r[lane];
  assign yl    = y_r[lane];
  assign s1_rd = s1_mem[mi];
  assign s2_rd = s2_mem[mi];

  // Rounding (half up) to 23 fractional bits of the Q.53 products
  assign rnd_p  = prod + 68'sd536870912;
  assign rnd_n  = -prod + 68'sd536870912;
  assign rnd_s2 = -{{12{p1_r[55]}}, p1_r} - prod + 68'sd536870912;
  assign r30_p  = rnd_p[67:30];
  assign r30_n  = rnd_n[67:30];
  assign r30_s2 = rnd_s2[67:30];

  assign esum  = acc_r + (k_r[0] ? {1'b0, prod[40:0], 24'd0} : {25'd0, prod[40:0]});
  assign ssum  = acc_r + {32'd0, prod[33:0]};
  assign sq    = prod[63:31];
  assign dlog  = $signed({1'b0, lb_r}) - $signed({1'b0, lf_r});
  assign rnd24 = prod + 68'sd8388608;
  assign csel  = (tgt_r > sr_r) ? att_r : rel_r;
  assign kin   = (in_tuser > MAXCH) ? MAXCH : in_tuser;
  assign ecf   = prod[35:0] + 36'd32768;
  assign rlin  = prod + 68'sd536870912;

  assign in_tready = (state_r == sbde_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ch_nxt = ch_r; kept_nxt = kept_r; k_nxt = k_r;
    x_nxt = x_r; y_nxt = y_r;
    p1_nxt = p1_r; bsq_nxt = bsq_r; fsq_nxt = fsq_r; acc_nxt = acc_r;
    be_nxt = be_r; fe_nxt = fe_r;
    lgv_nxt = lgv_r; lgn_nxt = lgn_r; lgm_nxt = lgm_r; lgf_nxt = lgf_r;
    lsel_nxt = lsel_r; lb_nxt = lb_r; lf_nxt = lf_r;
    ex_nxt = ex_r; tgt_nxt = tgt_r; sr_nxt = sr_r;
    ip_nxt = ip_r; fp_nxt = fp_r; lin_nxt = lin_r; g_nxt = g_r;
    ov_nxt = ov_r;
    out_load = 1'b0;
    s1_we = 1'b0; s2_we = 1'b0;
    s1_wd = sbde_pkg::sat32(40'(r30_n) + 40'(s2_rd));
    s2_wd = sbde_pkg::sat32(40'(r30_s2));
    mul_a = '0; mul_b = '0;

    if (out_tvalid && out_tready) ov_nxt = 1'b0;

    case (state_r)
      sbde_pkg::S_IDLE: begin
        if (in_tvalid) begin
          for (int i = 0; i < sbde_pkg::LANES; i++) x_nxt[i] = in_tdata[i*24 +: 24];
          kept_nxt = kin;
          ch_nxt = '0;
          bsq_nxt = '0;
          fsq_nxt = '0;
          if (!enabled_r || kin == 4'd0) state_nxt = sbde_pkg::S_DISMUL;
          else state_nxt = sbde_pkg::S_B0X;
        end
      end
      sbde_pkg::S_B0X: begin
        mul_a = {3'd0, b0_r};
        mul_b = 34'(xl);
        state_nxt = sbde_pkg::S_Y;
      end
      sbde_pkg::S_Y: begin
        p1_nxt = prod[55:0];
        y_nxt[lane] = sbde_pkg::sat24(40'(r30_p) + 40'(s1_rd));
        state_nxt = sbde_pkg::S_A1Y;
      end
      sbde_pkg::S_A1Y: begin
        mul_a = 34'($signed(a1_r));
        mul_b = 34'(yl);
        state_nxt = sbde_pkg::S_A2Y;
      end
      sbde_pkg::S_A2Y: begin
        s1_we = 1'b1;
        mul_a = 34'sd1073741824 - $signed({2'd0, b0_r, 1'b0});
        mul_b = 34'(yl);
        state_nxt = sbde_pkg::S_S2;
      end
      sbde_pkg::S_S2: begin
        s2_we = 1'b1;
        mul_a = 34'(yl);
        mul_b = 34'(yl);
        state_nxt = sbde_pkg::S_YY;
      end
      sbde_pkg::S_YY: begin
        bsq_nxt = bsq_r + prod[49:0];
        mul_a = 34'(xl);
        mul_b = 34'(xl);
        state_nxt = sbde_pkg::S_XX;
      end
      sbde_pkg::S_XX: begin
        fsq_nxt = fsq_r + prod[49:0];
        ch_nxt = ch_r + 4'd1;
        if (ch_r + 4'd1 == kept_r) begin
          k_nxt = '0;
          acc_nxt = '0;
          state_nxt = sbde_pkg::S_EMUL;
        end else begin
          state_nxt = sbde_pkg::S_B0X;
        end
      end
      sbde_pkg::S_EMUL: begin
        // One-pole detectors: the 48-bit state is split into two 24-bit halves
        mul_a = k_r[1] ? {17'd0, DCOMPL} : {18'd0, DCOEF};
        case (k_r[2:0])
          3'd0:    mul_b = {10'd0, be_r[23:0]};
          3'd1:    mul_b = {10'd0, be_r[47:24]};
          3'd2:    mul_b = {10'd0, bsq_r[25:2]};
          3'd3:    mul_b = {10'd0, bsq_r[49:26]};
          3'd4:    mul_b = {10'd0, fe_r[23:0]};
          3'd5:    mul_b = {10'd0, fe_r[47:24]};
          3'd6:    mul_b = {10'd0, fsq_r[25:2]};
          default: mul_b = {10'd0, fsq_r[49:26]};
        endcase
        state_nxt = sbde_pkg::S_EACC;
      end
      sbde_pkg::S_EACC: begin
        acc_nxt = esum;
        k_nxt = k_r + 4'd1;
        state_nxt = sbde_pkg::S_EMUL;
        if (k_r[1:0] == 2'd3) begin
          acc_nxt = '0;
          if (k_r[2]) begin
            fe_nxt = esum[63:16];
            lsel_nxt = 1'b0;
            state_nxt = sbde_pkg::S_LLOAD;
          end else begin
            be_nxt = esum[63:16];
          end
        end
      end
      sbde_pkg::S_LLOAD: begin
        lgv_nxt = {1'b0, lsel_r ? fe_r : be_r} + 49'(sbde_pkg::ENERGY_FLOOR);
        lgn_nxt = 6'd48;
        state_nxt = sbde_pkg::S_LNORM;
      end
      sbde_pkg::S_LNORM: begin
        if (lgv_r[48]) begin
          lgm_nxt = lgv_r[48:17];
          lgf_nxt = '0;
          k_nxt = '0;
          state_nxt = sbde_pkg::S_LSQ;
        end else begin
          lgv_nxt = {lgv_r[47:0], 1'b0};
          lgn_nxt = lgn_r - 6'd1;
        end
      end
      sbde_pkg::S_LSQ: begin
        mul_a = {2'd0, lgm_r};
        mul_b = {2'd0, lgm_r};
        state_nxt = sbde_pkg::S_LSTEP;
      end
      sbde_pkg::S_LSTEP: begin
        lgm_nxt = sq[32] ? sq[32:1] : sq[31:0];
        lgf_nxt = {lgf_r[14:0], sq[32]};
        k_nxt = k_r + 4'd1;
        state_nxt = sbde_pkg::S_LSQ;
        if (k_r == 4'd15) begin
          if (lsel_r) begin
            lf_nxt = {lgn_r, lgf_r[14:0], sq[32]};
            state_nxt = sbde_pkg::S_DBMUL;
          end else begin
            lb_nxt = {lgn_r, lgf_r[14:0], sq[32]};
            lsel_nxt = 1'b1;
            state_nxt = sbde_pkg::S_LLOAD;
          end
        end
      end
      sbde_pkg::S_DBMUL: begin
        mul_a = 34'(dlog);
        mul_b = {16'd0, sbde_pkg::DB_PER_LOG2};
        state_nxt = sbde_pkg::S_DBEXC;
      end
      sbde_pkg::S_DBEXC: begin
        ex_nxt = $signed(rnd24[45:24]) - 22'($signed(thr_r));
        if ($signed(rnd24[45:24]) - 22'($signed(thr_r)) > 22'sd0) begin
          state_nxt = sbde_pkg::S_AMT;
        end else begin
          tgt_nxt = '0;
          k_nxt = '0;
          acc_nxt = '0;
          state_nxt = sbde_pkg::S_SRMUL;
        end
      end
      sbde_pkg::S_AMT: begin
        mul_a = 34'(ex_r);
        mul_b = {20'd0, amt_r};
        state_nxt = sbde_pkg::S_TGT;
      end
      sbde_pkg::S_TGT: begin
        tgt_nxt = (prod[33:12] > {9'd0, maxr_r}) ? maxr_r : prod[24:12];
        k_nxt = '0;
        acc_nxt = '0;
        state_nxt = sbde_pkg::S_SRMUL;
      end
      sbde_pkg::S_SRMUL: begin
        if (k_r[0]) begin
          mul_a = {17'd0, 17'd65536 - {1'b0, csel}};
          mul_b = {21'd0, tgt_r};
        end else begin
          mul_a = {18'd0, csel};
          mul_b = {21'd0, sr_r};
        end
        state_nxt = sbde_pkg::S_SRACC;
      end
      sbde_pkg::S_SRACC: begin
        acc_nxt = ssum;
        k_nxt = k_r + 4'd1;
        state_nxt = sbde_pkg::S_SRMUL;
        if (k_r[0]) begin
          sr_nxt = ssum[28:16];
          state_nxt = (ssum[28:16] == 13'd0) ? sbde_pkg::S_DONE : sbde_pkg::S_CFMUL;
        end
      end
      sbde_pkg::S_DISMUL: begin
        mul_a = {18'd0, rel_r};
        mul_b = {21'd0, sr_r};
        state_nxt = sbde_pkg::S_DISACC;
      end
      sbde_pkg::S_DISACC: begin
        sr_nxt = prod[28:16];
        state_nxt = sbde_pkg::S_DONE;
      end
      sbde_pkg::S_CFMUL: begin
        mul_a = {21'd0, sr_r};
        mul_b = {12'd0, sbde_pkg::LOG2_10_Q24};
        state_nxt = sbde_pkg::S_CFEXP;
      end
      sbde_pkg::S_CFEXP: begin
        ip_nxt = ecf[35:32];
        fp_nxt = ecf[31:16];
        lin_nxt = 31'h40000000;
        k_nxt = '0;
        state_nxt = sbde_pkg::S_CFMUL2;
      end
      sbde_pkg::S_CFMUL2: begin
        mul_a = {3'd0, lin_r};
        mul_b = {3'd0, sbde_pkg::SQRT_TAB[k_r*31 +: 31]};
        state_nxt = sbde_pkg::S_CFSTEP;
      end
      sbde_pkg::S_CFSTEP: begin
        if (fp_r[15]) lin_nxt = rlin[60:30];
        fp_nxt = {fp_r[14:0], 1'b0};
        k_nxt = k_r + 4'd1;
        state_nxt = (k_r == 4'd15) ? sbde_pkg::S_CFSHIFT : sbde_pkg::S_CFMUL2;
      end
      sbde_pkg::S_CFSHIFT: begin
        g_nxt = 31'h40000000 - (lin_r >> ip_r);
        ch_nxt = '0;
        state_nxt = sbde_pkg::S_SUBMUL;
      end
      sbde_pkg::S_SUBMUL: begin
        mul_a = {3'd0, g_r};
        mul_b = 34'(yl);
        state_nxt = sbde_pkg::S_SUBACC;
      end
      sbde_pkg::S_SUBACC: begin
        x_nxt[lane] = sbde_pkg::sat24(40'(xl) - 40'(r30_p));
        ch_nxt = ch_r + 4'd1;
        state_nxt = (ch_r + 4'd1 == kept_r) ? sbde_pkg::S_DONE : sbde_pkg::S_SUBMUL;
      end
      sbde_pkg::S_DONE: begin
        if (!out_tvalid || out_tready) begin
          out_load = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = sbde_pkg::S_IDLE;
        end
      end
      default: state_nxt = sbde_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbde_pkg::S_IDLE;
      ch_r    <= '0;
      kept_r  <= '0;
      k_r     <= '0;
      lsel_r  <= 1'b0;
      be_r    <= '0;
      fe_r    <= '0;
      sr_r    <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        s1_mem[i] <= '0;
        s2_mem[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      kept_r  <= kept_nxt;
      k_r     <= k_nxt;
      lsel_r  <= lsel_nxt;
      be_r    <= be_nxt;
      fe_r    <= fe_nxt;
      sr_r    <= sr_nxt;
      ov_r    <= ov_nxt;
      if (s1_we) s1_mem[mi] <= s1_wd;
      if (s2_we) s2_mem[mi] <= s2_wd;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    p1_r <= p1_nxt;
    bsq_r <= bsq_nxt;
    fsq_r <= fsq_nxt;
    acc_r <= acc_nxt;
    lgv_r <= lgv_nxt;
    lgn_r <= lgn_nxt;
    lgm_r <= lgm_nxt;
    lgf_r <= lgf_nxt;
    lb_r <= lb_nxt;
    lf_r <= lf_nxt;
    ex_r <= ex_nxt;
    tgt_r <= tgt_nxt;
    ip_r <= ip_nxt;
    fp_r <= fp_nxt;
    lin_r <= lin_nxt;
    g_r <= g_nxt;
    if (out_load) begin
      ox_r <= x_r;
      ordb_r <= sr_r;
    end
  end

  assign out_tvalid = ov_r;

  always_comb begin
    out_tdata = '0;
    for (int i = 0; i < sbde_pkg::LANES; i++) out_tdata[i*24 +: 24] = ox_r[i];
    out_tdata[204:192] = ordb_r;
  end

  // A finished frame always becomes a pending output transaction.
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sbde_pkg::S_DONE && (!out_tvalid || out_tready)) |=> out_tvalid)
    else $error("finished frame not presented on the output");

  // The channel counter stays inside the frame while the bandpass or the subtraction runs.
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sbde_pkg::S_B0X || state_r == sbde_pkg::S_SUBMUL) |-> (ch_r < kept_r))
    else $error("channel counter beyond active channels");

  // The target never exceeds the cap when the reduction smoother starts.
  a_tgt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sbde_pkg::S_SRMUL) |-> (tgt_r <= maxr_r))
    else $error("target reduction above cap");

  // Squaring steps always start from a normalised mantissa.
  a_log_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sbde_pkg::S_LSQ) |-> lgm_r[31])
    else $error("log mantissa not normalised");

endmodule
`default_nettype wire

// File: hdl/sbde_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none
module sbde_mul #(
  parameter int W = sbde_pkg::MUL_W
) (
  input  wire logic                  clk,
  input  wire logic signed [W-1:0]   a,
  input  wire logic signed [W-1:0]   b,
  output logic signed [2*W-1:0]      prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule
`default_nettype wire
